FILE: src/sqvs_pkg.sv
// Shared constants, types and the quarter-wave sine generator for sprite quad setup.
package sqvs_pkg;

  localparam int MAX_QUADS       = 4096;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QCNT_W          = $clog2(MAX_QUADS + 1);
  localparam int QBITS           = SINE_TABLE_BITS - 2;
  localparam int QN              = 1 << QBITS;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_BITS       = $clog2(QDEPTH + 1);

  localparam logic [15:0] TEX_INVALID = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_VERTEX    = 3'd0,
    KIND_DROP_FULL = 3'd1,
    KIND_DROP_TEX  = 3'd2,
    KIND_FLUSH     = 3'd3,
    KIND_BEGIN     = 3'd4
  } kind_t;

  // one classified command; fields a kind does not use are zero
  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [23:0]        z;
    logic [23:0]        w;
    logic [23:0]        h;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic [31:0]        color;
    logic [15:0]        vidx;
    logic [14:0]        icnt;
    logic [15:0]        tex;
    logic [15:0]        pipe;
  } qent_t;

  // Q1.15 polynomial sine over one quarter wave; elaborated with constant arguments only
  function automatic logic [15:0] quarter_sine(input logic [15:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (64'(x) * 64'(x)) >> 15;
    t  = (64'd2320 * x2) >> 15;
    t  = 64'd21024 - t;
    t  = (t * x2) >> 15;
    t  = 64'd51472 - t;
    t  = (t * 64'(x)) >> 15;
    if (t > 64'd32767) t = 64'd32767;
    return t[15:0];
  endfunction

  localparam logic [15:0] QSIN_PEAK = quarter_sine(16'h8000);

endpackage

FILE: src/sqvs_queue.sv
// Small register FIFO between the classifying front and the vertex back end.
module sqvs_queue import sqvs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output qent_t rdata
);

  qent_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_BITS'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: src/sqvs_front.sv
// Front end: takes commands, keeps batch state, looks up sin/cos and queues work.
module sqvs_front import sqvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [23:0] in_center_x,
  input  logic signed [23:0] in_center_y,
  input  logic signed [23:0] in_depth_z,
  input  logic [23:0]        in_quad_width,
  input  logic [23:0]        in_quad_height,
  input  logic [15:0]        in_rotation_angle,
  input  logic [31:0]        in_quad_color,
  input  logic [15:0]        in_texture_id,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_pipeline_handle,
  input  logic               q_full,
  output logic               q_push,
  output qent_t              q_wdata
);

  logic [QCNT_W-1:0]          quads_r, quads_nxt;
  logic [14:0]                verts_r, verts_nxt;
  logic [15:0]                batch_r, batch_nxt;
  logic [15:0]                pipe_r;
  logic                       acc;
  logic [15:0]                eff_tex;
  logic [12:0]                quad_cnt;
  logic [15:0]                qtab [QN];
  logic [SINE_TABLE_BITS-1:0] kk [2];
  logic signed [15:0]         trig [2];

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign acc       = in_valid && !q_full;

  for (genvar g = 0; g < QN; g++) begin : g_qtab
    assign qtab[g] = quarter_sine(16'(g << (15 - QBITS)));
  end

  // lane 0 is sin, lane 1 is cos (a quarter turn ahead)
  assign kk[0] = in_rotation_angle[15 -: SINE_TABLE_BITS];
  assign kk[1] = kk[0] + SINE_TABLE_BITS'(QN);

  always_comb begin
    logic [1:0]       quadrant;
    logic [QBITS-1:0] r;
    logic [15:0]      mag;
    for (int l = 0; l < 2; l++) begin
      quadrant = kk[l][SINE_TABLE_BITS-1 -: 2];
      r        = kk[l][QBITS-1:0];
      if (quadrant[0]) begin
        // mirrored quarter: entry QN - r, peak value when r is zero
        mag = (r == '0) ? QSIN_PEAK : qtab[QBITS'(0) - r];
      end else begin
        mag = qtab[r];
      end
      trig[l] = quadrant[1] ? -$signed(mag) : $signed(mag);
    end
  end

  assign eff_tex  = (batch_r == TEX_INVALID) ? in_texture_id : batch_r;
  assign quad_cnt = verts_r[14:2];

  always_comb begin
    quads_nxt = quads_r;
    verts_nxt = verts_r;
    batch_nxt = batch_r;
    q_push    = 1'b0;
    q_wdata   = '0;
    if (acc) begin
      case (in_command)
        CMD_BEGIN: begin
          quads_nxt    = '0;
          verts_nxt    = '0;
          batch_nxt    = TEX_INVALID;
          q_push       = 1'b1;
          q_wdata.kind = KIND_BEGIN;
        end
        CMD_FLUSH: begin
          if (verts_r != '0) begin
            q_push       = 1'b1;
            q_wdata.kind = KIND_FLUSH;
            q_wdata.vidx = 16'(verts_r);
            q_wdata.icnt = {quad_cnt, 2'b00} + {1'b0, quad_cnt, 1'b0};
            q_wdata.tex  = batch_r;
            q_wdata.pipe = pipe_r;
            verts_nxt    = '0;
          end
        end
        CMD_SUBMIT: begin
          q_push = 1'b1;
          if (quads_r >= QCNT_W'(MAX_QUADS)) begin
            q_wdata.kind = KIND_DROP_FULL;
          end else begin
            batch_nxt = eff_tex;
            if (in_texture_id != eff_tex) begin
              q_wdata.kind = KIND_DROP_TEX;
            end else begin
              q_wdata.kind  = KIND_VERTEX;
              q_wdata.cx    = in_center_x;
              q_wdata.cy    = in_center_y;
              q_wdata.z     = in_depth_z;
              q_wdata.w     = in_quad_width;
              q_wdata.h     = in_quad_height;
              q_wdata.sin_v = trig[0];
              q_wdata.cos_v = trig[1];
              q_wdata.color = in_quad_color;
              q_wdata.vidx  = 16'(verts_r);
              verts_nxt     = verts_r + 15'd4;
              quads_nxt     = quads_r + QCNT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quads_r <= '0;
      verts_r <= '0;
      batch_r <= TEX_INVALID;
      pipe_r  <= '0;
    end else begin
      quads_r <= quads_nxt;
      verts_r <= verts_nxt;
      batch_r <= batch_nxt;
      if (cfg_valid) begin
        pipe_r <= cfg_pipeline_handle;
      end
    end
  end

endmodule

FILE: src/sqvs_back.sv
// Back end: rotation products, per-corner offsets, and the saturating output register.
module sqvs_back import sqvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  qent_t              q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic               out_tex_u,
  output logic               out_tex_v,
  output logic [31:0]        out_vertex_color,
  output logic [15:0]        out_vertex_index,
  output logic [14:0]        out_index_total,
  output logic [15:0]        out_batch_texture_out,
  output logic [15:0]        out_pipeline_out,
  output logic               out_last
);

  // product stage
  logic               m_vld_r, m_vld_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  qent_t              m_r;
  logic signed [40:0] wc_r, ws_r, hc_r, hs_r;
  logic signed [24:0] w_s, h_s;
  logic signed [40:0] wc_nxt, ws_nxt, hc_nxt, hs_nxt;
  logic               m_fire, m_last;

  // corner stage
  logic               c_vld_r, c_vld_nxt;
  kind_t              c_kind_r;
  logic signed [23:0] c_cx_r, c_cy_r;
  logic [23:0]        c_z_r;
  logic signed [25:0] c_rx_r, c_ry_r;
  logic               c_u_r, c_v_r, c_last_r;
  logic [31:0]        c_color_r;
  logic [15:0]        c_vidx_r, c_tex_r, c_pipe_r;
  logic [14:0]        c_icnt_r;
  logic               c_u, c_v;
  logic signed [41:0] rx_sum, ry_sum;
  logic               c_can;

  // output stage
  logic               o_vld_r, o_vld_nxt;
  logic               o_can, o_load;
  kind_t              o_kind_r;
  logic signed [23:0] o_px_r, o_py_r;
  logic [23:0]        o_z_r;
  logic               o_u_r, o_v_r, o_last_r;
  logic [31:0]        o_color_r;
  logic [15:0]        o_vidx_r, o_tex_r, o_pipe_r;
  logic [14:0]        o_icnt_r;
  logic signed [26:0] px_sum, py_sum;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  assign o_can  = !o_vld_r || !out_stall;
  assign c_can  = !c_vld_r || o_can;
  assign o_load = c_vld_r && o_can;
  assign m_fire = m_vld_r && c_can;
  assign m_last = (m_r.kind != KIND_VERTEX) || (cnt_r == 2'd3);
  assign q_pop  = q_valid && (!m_vld_r || (m_fire && m_last));

  assign w_s    = {1'b0, q_rdata.w};
  assign h_s    = {1'b0, q_rdata.h};
  assign wc_nxt = w_s * q_rdata.cos_v;
  assign ws_nxt = w_s * q_rdata.sin_v;
  assign hc_nxt = h_s * q_rdata.cos_v;
  assign hs_nxt = h_s * q_rdata.sin_v;

  always_comb begin
    m_vld_nxt = m_vld_r;
    cnt_nxt   = cnt_r;
    if (q_pop) begin
      m_vld_nxt = 1'b1;
      cnt_nxt   = '0;
    end else if (m_fire) begin
      if (m_last) begin
        m_vld_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 2'd1;
      end
    end
  end

  // corners run (0,0),(1,0),(1,1),(0,1); u set means +x half, v set means +y half
  assign c_u = (m_r.kind == KIND_VERTEX) && (cnt_r[0] ^ cnt_r[1]);
  assign c_v = (m_r.kind == KIND_VERTEX) && cnt_r[1];

  always_comb begin
    logic signed [41:0] wc_e, ws_e, hc_e, hs_e;
    wc_e   = 42'(wc_r);
    ws_e   = 42'(ws_r);
    hc_e   = 42'(hc_r);
    hs_e   = 42'(hs_r);
    rx_sum = (c_u ? wc_e : -wc_e) + (c_v ? -hs_e : hs_e) + 42'sd32768;
    ry_sum = (c_u ? ws_e : -ws_e) + (c_v ? hc_e : -hc_e) + 42'sd32768;
  end

  assign c_vld_nxt = m_fire || (c_vld_r && !o_can);
  assign o_vld_nxt = o_load || (o_vld_r && out_stall);

  assign px_sum = 27'(c_cx_r) + 27'(c_rx_r);
  assign py_sum = 27'(c_cy_r) + 27'(c_ry_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      cnt_r   <= '0;
      c_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      m_vld_r <= m_vld_nxt;
      cnt_r   <= cnt_nxt;
      c_vld_r <= c_vld_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_r  <= q_rdata;
      wc_r <= wc_nxt;
      ws_r <= ws_nxt;
      hc_r <= hc_nxt;
      hs_r <= hs_nxt;
    end
    if (m_fire) begin
      c_kind_r  <= m_r.kind;
      c_cx_r    <= m_r.cx;
      c_cy_r    <= m_r.cy;
      c_z_r     <= m_r.z;
      c_rx_r    <= rx_sum[41:16];
      c_ry_r    <= ry_sum[41:16];
      c_u_r     <= c_u;
      c_v_r     <= c_v;
      c_last_r  <= m_last;
      c_color_r <= m_r.color;
      c_vidx_r  <= (m_r.kind == KIND_VERTEX) ? m_r.vidx + 16'(cnt_r) : m_r.vidx;
      c_icnt_r  <= m_r.icnt;
      c_tex_r   <= m_r.tex;
      c_pipe_r  <= m_r.pipe;
    end
    if (o_load) begin
      o_kind_r  <= c_kind_r;
      o_px_r    <= sat24(px_sum);
      o_py_r    <= sat24(py_sum);
      o_z_r     <= c_z_r;
      o_u_r     <= c_u_r;
      o_v_r     <= c_v_r;
      o_last_r  <= c_last_r;
      o_color_r <= c_color_r;
      o_vidx_r  <= c_vidx_r;
      o_icnt_r  <= c_icnt_r;
      o_tex_r   <= c_tex_r;
      o_pipe_r  <= c_pipe_r;
    end
  end

  assign out_valid             = o_vld_r;
  assign out_kind              = o_kind_r;
  assign out_pos_x             = o_px_r;
  assign out_pos_y             = o_py_r;
  assign out_pos_z             = o_z_r;
  assign out_tex_u             = o_u_r;
  assign out_tex_v             = o_v_r;
  assign out_vertex_color      = o_color_r;
  assign out_vertex_index      = o_vidx_r;
  assign out_index_total       = o_icnt_r;
  assign out_batch_texture_out = o_tex_r;
  assign out_pipeline_out      = o_pipe_r;
  assign out_last              = o_last_r;

endmodule

FILE: src/sprite_quad_vertex_setup_core.sv
// Top level of the sprite quad vertex setup block.
//
// Input channel (in_valid / in_stall) takes one command word per cycle while
// in_stall is low: submit quad, begin frame or flush batch. The output channel
// (out_valid / out_stall) gives result words: four vertices for an accepted
// quad, one word for a drop, a begin or a non-empty flush; out_last marks
// the final word of each command. The cfg channel (cfg_valid / cfg_ready,
// ready always high) loads the pipeline handle reported on flush.
// A command word is written into the queue, then registered in the product,
// corner and output stages before it shows on out_valid. A quad gives four
// vertices, one per cycle while out_stall is low; other commands give one word.
// The front end classifies a command in its accept cycle, so commands with
// no result finish there. A four-entry queue sits between front and back;
// in_stall rises only while that queue is full, so a stalled output backs up
// through the back end stages and then the queue.
// Reset (rst_n low, synchronous) empties all stages, clears the quad and
// vertex counts, marks the batch texture invalid and zeroes the handle.
module sprite_quad_vertex_setup_core import sqvs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [23:0] in_center_x,
  input  logic signed [23:0] in_center_y,
  input  logic signed [23:0] in_depth_z,
  input  logic [23:0]        in_quad_width,
  input  logic [23:0]        in_quad_height,
  input  logic [15:0]        in_rotation_angle,
  input  logic [31:0]        in_quad_color,
  input  logic [15:0]        in_texture_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic               out_tex_u,
  output logic               out_tex_v,
  output logic [31:0]        out_vertex_color,
  output logic [15:0]        out_vertex_index,
  output logic [14:0]        out_index_total,
  output logic [15:0]        out_batch_texture_out,
  output logic [15:0]        out_pipeline_out,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_pipeline_handle
);

  logic  q_full, q_push, q_pop, q_not_empty;
  qent_t q_wdata, q_rdata;

  sqvs_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_center_x         (in_center_x),
    .in_center_y         (in_center_y),
    .in_depth_z          (in_depth_z),
    .in_quad_width       (in_quad_width),
    .in_quad_height      (in_quad_height),
    .in_rotation_angle   (in_rotation_angle),
    .in_quad_color       (in_quad_color),
    .in_texture_id       (in_texture_id),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_pipeline_handle (cfg_pipeline_handle),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_wdata             (q_wdata)
  );

  sqvs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  sqvs_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_not_empty),
    .q_rdata               (q_rdata),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_kind              (out_kind),
    .out_pos_x             (out_pos_x),
    .out_pos_y             (out_pos_y),
    .out_pos_z             (out_pos_z),
    .out_tex_u             (out_tex_u),
    .out_tex_v             (out_tex_v),
    .out_vertex_color      (out_vertex_color),
    .out_vertex_index      (out_vertex_index),
    .out_index_total       (out_index_total),
    .out_batch_texture_out (out_batch_texture_out),
    .out_pipeline_out      (out_pipeline_out),
    .out_last              (out_last)
  );

endmodule
